// ===== sv/pdf_pkg.sv =====
// ----------------------------------------------------------------------------
// pdf_pkg
// Shared types, constants and helpers for the packet deframer.
// ----------------------------------------------------------------------------
package pdf_pkg;

    localparam logic [8:0] HEADER_BYTES = 9'd4;

    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    localparam logic [7:0] TYPE_SYNC      = 8'h80;
    localparam logic [7:0] TYPE_01        = 8'h01;
    localparam logic [7:0] TYPE_02        = 8'h02;
    localparam logic [7:0] TYPE_03        = 8'h03;
    localparam logic [7:0] TYPE_04        = 8'h04;
    localparam logic [7:0] TYPE_05        = 8'h05;
    localparam logic [7:0] TYPE_PAYLOAD82 = 8'h82;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] data_out;
        logic [8:0] offset;
        logic       first_byte;
        logic       last_byte;
        logic       checksum_error;
        logic       aborted;
    } t_result;

    function automatic logic is_known_type(input logic [7:0] b);
        logic known;
        known = 1'b0;
        case (b) inside
            TYPE_01, TYPE_02, TYPE_03, TYPE_04, TYPE_05,
            TYPE_SYNC, TYPE_PAYLOAD82: known = 1'b1;
            default:                   known = 1'b0;
        endcase
        return known;
    endfunction

endpackage

// ===== sv/packet_deframer_with_checksum_unit.sv =====
// An input transfer lands in the input register; any result moves to the result register.
// Throughput: one item per cycle unless stalled; framing state updates once per item.
// A stalled output holds the result and backs up the input register only when
// the waiting item would itself produce a result.
// Reset: synchronous active-low i_rst_n empties both registers and returns the
// framer to idle (no open packet, zero sum).
// ----------------------------------------------------------------------------
// packet_deframer_with_checksum_unit
// Splits a received byte stream into packets, tags offsets and checks sums.
// ----------------------------------------------------------------------------
module packet_deframer_with_checksum_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_kind,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data_out,
    output logic [8:0] o_offset,
    output logic       o_first_byte,
    output logic       o_last_byte,
    output logic       o_checksum_error,
    output logic       o_aborted
);
    import pdf_pkg::*;

    t_item   in_item;
    t_item   st_item;
    logic    st_valid;
    logic    take;
    logic    load;
    logic    out_free;
    t_result fr_result;
    t_result out_result;

    assign in_item.kind    = i_kind;
    assign in_item.rx_byte = i_rx_byte;

    pdf_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_item       (in_item),
        .i_take       (take),
        .o_item_valid (st_valid),
        .o_item       (st_item)
    );

    pdf_framer u_framer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (st_valid),
        .i_item       (st_item),
        .i_out_free   (out_free),
        .o_take       (take),
        .o_load       (load),
        .o_result     (fr_result)
    );

    pdf_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_result (fr_result),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_result)
    );

    assign o_data_out       = out_result.data_out;
    assign o_offset         = out_result.offset;
    assign o_first_byte     = out_result.first_byte;
    assign o_last_byte      = out_result.last_byte;
    assign o_checksum_error = out_result.checksum_error;
    assign o_aborted        = out_result.aborted;

endmodule

// ===== sv/pdf_in_stage.sv =====
// ----------------------------------------------------------------------------
// pdf_in_stage
// Input register: captures one item per transfer, holds it until taken.
// ----------------------------------------------------------------------------
module pdf_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  pdf_pkg::t_item i_item,
    input  logic          i_take,
    output logic          o_item_valid,
    output pdf_pkg::t_item o_item
);
    import pdf_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    always_comb begin
        o_ready = !r_valid || i_take;
        n_valid = o_ready ? i_valid : r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

// ===== sv/pdf_framer.sv =====
// ----------------------------------------------------------------------------
// pdf_framer
// Framing state, checksum accumulation and result formation for one item.
// ----------------------------------------------------------------------------
module pdf_framer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_item_valid,
    input  pdf_pkg::t_item   i_item,
    input  logic             i_out_free,
    output logic             o_take,
    output logic             o_load,
    output pdf_pkg::t_result o_result
);
    import pdf_pkg::*;

    logic [8:0] r_byte_count;
    logic [8:0] r_expected_size;
    logic       r_has_payload;
    logic [7:0] r_running_sum;

    logic [8:0] n_byte_count;
    logic [8:0] n_expected_size;
    logic       n_has_payload;
    logic [7:0] n_running_sum;

    logic    produce;
    logic    idle;
    logic [7:0] sum_add;
    logic [8:0] exp_upd;
    logic [8:0] cnt_inc;
    t_result res;

    always_comb begin
        idle    = (r_byte_count == 9'd0);
        sum_add = r_running_sum + i_item.rx_byte;
        cnt_inc = r_byte_count + 9'd1;
        exp_upd = r_expected_size;
        if (r_byte_count == 9'd1 && r_has_payload) begin
            exp_upd = HEADER_BYTES + {1'b0, i_item.rx_byte} + 9'd1;
        end

        produce         = 1'b0;
        res             = '0;
        n_byte_count    = r_byte_count;
        n_expected_size = r_expected_size;
        n_has_payload   = r_has_payload;
        n_running_sum   = r_running_sum;

        if (i_item.kind == KIND_TIMEOUT) begin
            if (!idle) begin
                // abort the partial packet and return to idle
                produce         = 1'b1;
                res.last_byte   = 1'b1;
                res.aborted     = 1'b1;
                n_byte_count    = 9'd0;
                n_expected_size = HEADER_BYTES;
                n_has_payload   = 1'b0;
                n_running_sum   = 8'd0;
            end
        end else if (idle) begin
            // drop anything that is not a known type code
            if (is_known_type(i_item.rx_byte)) begin
                produce         = 1'b1;
                res.data_out    = i_item.rx_byte;
                res.first_byte  = 1'b1;
                n_has_payload   = i_item.rx_byte[7];
                n_expected_size = HEADER_BYTES;
                n_running_sum   = i_item.rx_byte;
                n_byte_count    = 9'd1;
            end
        end else begin
            produce      = 1'b1;
            res.data_out = i_item.rx_byte;
            res.offset   = r_byte_count;
            if (cnt_inc >= exp_upd) begin
                res.last_byte      = 1'b1;
                res.checksum_error = r_has_payload && (sum_add != 8'd0);
                n_byte_count       = 9'd0;
                n_expected_size    = HEADER_BYTES;
                n_has_payload      = 1'b0;
                n_running_sum      = 8'd0;
            end else begin
                n_byte_count    = cnt_inc;
                n_expected_size = exp_upd;
                n_running_sum   = sum_add;
            end
        end

        o_take   = i_item_valid && (!produce || i_out_free);
        o_load   = o_take && produce;
        o_result = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count    <= 9'd0;
            r_expected_size <= HEADER_BYTES;
            r_has_payload   <= 1'b0;
            r_running_sum   <= 8'd0;
        end else if (o_take) begin
            r_byte_count    <= n_byte_count;
            r_expected_size <= n_expected_size;
            r_has_payload   <= n_has_payload;
            r_running_sum   <= n_running_sum;
        end
    end

endmodule

// ===== sv/pdf_out_stage.sv =====
// ----------------------------------------------------------------------------
// pdf_out_stage
// Result register: holds one result until the downstream transfer.
// ----------------------------------------------------------------------------
module pdf_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  pdf_pkg::t_result i_result,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output pdf_pkg::t_result o_result
);
    import pdf_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    always_comb begin
        o_free  = !r_valid || i_ready;
        n_valid = i_load || (r_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== sv/pdf_checker.sv =====
// ----------------------------------------------------------------------------
// pdf_checker
// Port-level checks on the deframer's result stream.
// ----------------------------------------------------------------------------
module pdf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_data_out,
    input logic [8:0] o_offset,
    input logic       o_first_byte,
    input logic       o_last_byte,
    input logic       o_checksum_error,
    input logic       o_aborted
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data_out) && $stable(o_offset)
            && $stable(o_last_byte) && $stable(o_aborted))
        else $error("result changed while stalled");

    a_abort_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_aborted |-> o_last_byte && !o_first_byte && !o_checksum_error
            && o_data_out == 8'd0 && o_offset == 9'd0)
        else $error("malformed abort marker");

    a_first_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_first_byte |-> o_offset == 9'd0 && !o_last_byte
            && !o_checksum_error && !o_aborted)
        else $error("malformed type byte");

    // shortest payload packet ends at offset 4
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_checksum_error |-> o_last_byte && o_offset >= 9'd4)
        else $error("checksum error off the last byte");

    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_offset <= 9'd259)
        else $error("offset out of range");

endmodule

bind packet_deframer_with_checksum_unit pdf_checker u_pdf_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the packet deframer with directed frames, then with random
// frames mixed with noise bytes, timeouts and cut-off packets. Every output
// transfer is compared field by field against a behavioral deframer that
// tracks the open packet, its length and its byte sum.
// ----------------------------------------------------------------------------
module testbench;
    import pdf_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int ITEM_TARGET  = 750;
    localparam int QUIET_AFTER  = 650;
    localparam int DRAIN_CYCLES = 8;

    class deframe_scoreboard;
        logic [8:0] bytes_seen;
        logic [8:0] frame_len;
        logic       payload_frame;
        logic [7:0] byte_sum;
        t_result    frames_due[$];
        int         mismatches;
        int         results_checked;
        int         frames_closed;
        int         aborts_seen;
        int         sum_errors_seen;
        int         max_offset;

        function new();
            close_frame();
            mismatches      = 0;
            results_checked = 0;
            frames_closed   = 0;
            aborts_seen     = 0;
            sum_errors_seen = 0;
            max_offset      = 0;
        endfunction

        function void close_frame();
            bytes_seen    = 9'd0;
            frame_len     = HEADER_BYTES;
            payload_frame = 1'b0;
            byte_sum      = 8'd0;
        endfunction

        function bit is_frame_type(logic [7:0] b);
            case (b)
                TYPE_01, TYPE_02, TYPE_03, TYPE_04, TYPE_05,
                TYPE_SYNC, TYPE_PAYLOAD82: return 1'b1;
                default:                   return 1'b0;
            endcase
        endfunction

        // Advance the framing state by one accepted input transfer.
        function void note_input(logic kind, logic [7:0] b);
            t_result    r;
            bit         emit;
            logic [8:0] pos;
            r    = '0;
            emit = 1'b0;
            if (kind == KIND_TIMEOUT) begin
                if (bytes_seen != 9'd0) begin
                    r.last_byte = 1'b1;
                    r.aborted   = 1'b1;
                    emit        = 1'b1;
                    close_frame();
                end
            end else if (bytes_seen == 9'd0) begin
                if (is_frame_type(b)) begin
                    payload_frame = b[7];
                    frame_len     = HEADER_BYTES;
                    byte_sum      = b;
                    bytes_seen    = 9'd1;
                    r.data_out    = b;
                    r.first_byte  = 1'b1;
                    emit          = 1'b1;
                end
            end else begin
                pos        = bytes_seen;
                byte_sum   = byte_sum + b;
                // length byte sets the total: header, payload, checksum
                if (pos == 9'd1 && payload_frame)
                    frame_len = HEADER_BYTES + {1'b0, b} + 9'd1;
                bytes_seen = bytes_seen + 9'd1;
                r.data_out = b;
                r.offset   = pos;
                emit       = 1'b1;
                if (bytes_seen >= frame_len) begin
                    r.last_byte      = 1'b1;
                    r.checksum_error = payload_frame && (byte_sum != 8'd0);
                    close_frame();
                end
            end
            if (emit)
                frames_due.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        task compare_field(string name, int got, int want);
            if (got != want)
                report($sformatf("result %0d: %s is %0d, expected %0d",
                                 results_checked, name, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            if (frames_due.size() == 0) begin
                report($sformatf("unexpected result data %0h offset %0d",
                                 got.data_out, got.offset));
                return;
            end
            want = frames_due.pop_front();
            compare_field("data_out",       got.data_out,       want.data_out);
            compare_field("offset",         got.offset,         want.offset);
            compare_field("first_byte",     got.first_byte,     want.first_byte);
            compare_field("last_byte",      got.last_byte,      want.last_byte);
            compare_field("checksum_error", got.checksum_error, want.checksum_error);
            compare_field("aborted",        got.aborted,        want.aborted);
            results_checked++;
            if (want.last_byte && !want.aborted)
                frames_closed++;
            if (want.aborted)
                aborts_seen++;
            if (want.checksum_error)
                sum_errors_seen++;
            if (int'(want.offset) > max_offset)
                max_offset = want.offset;
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic       i_kind;
    logic [7:0] i_rx_byte;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_data_out;
    logic [8:0] o_offset;
    logic       o_first_byte;
    logic       o_last_byte;
    logic       o_checksum_error;
    logic       o_aborted;

    deframe_scoreboard sb;
    t_result           seen_result;
    int                items_sent;
    int                cycle_count;
    bit                quiet;

    packet_deframer_with_checksum_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_kind           (i_kind),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_data_out       (o_data_out),
        .o_offset         (o_offset),
        .o_first_byte     (o_first_byte),
        .o_last_byte      (o_last_byte),
        .o_checksum_error (o_checksum_error),
        .o_aborted        (o_aborted)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles", cycle_count);
        $display("TB_ERROR");
        $finish;
    end

    // Output side: stall in random bursts until the quiet tail.
    initial begin
        int stall;
        stall   = 0;
        i_ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                i_ready = 1'b0;
                stall--;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                i_ready = 1'b0;
                stall   = $urandom_range(0, 3);
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen_result.data_out       = o_data_out;
            seen_result.offset         = o_offset;
            seen_result.first_byte     = o_first_byte;
            seen_result.last_byte      = o_last_byte;
            seen_result.checksum_error = o_checksum_error;
            seen_result.aborted        = o_aborted;
            sb.check_result(seen_result);
        end
    end

    // Called just after a falling edge; returns just after a falling edge.
    task automatic push_item(input logic kind, input logic [7:0] b);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap     = $urandom_range(1, 4);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_kind    = kind;
        i_rx_byte = b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_input(kind, b);
        items_sent++;
        quiet = (items_sent >= QUIET_AFTER);
        @(negedge i_clk);
    endtask

    // Build one frame; payload frames get a length byte and a trailing checksum.
    task automatic send_frame(input logic [7:0] ptype, input int len, input bit good_sum,
                              input bit truncate);
        logic [7:0] frame[$];
        logic [7:0] acc;
        int         cut;
        frame.push_back(ptype);
        frame.push_back(ptype[7] ? len[7:0] : 8'($urandom));
        repeat (2) frame.push_back(8'($urandom));
        if (ptype[7]) begin
            repeat (len) frame.push_back(8'($urandom));
            acc = 8'h00;
            foreach (frame[k]) acc = acc + frame[k];
            if (good_sum)
                frame.push_back(8'h00 - acc);
            else
                frame.push_back(8'h00 - acc + 8'($urandom_range(1, 255)));
        end
        cut = truncate ? $urandom_range(1, frame.size() - 1) : frame.size();
        for (int k = 0; k < cut; k++)
            push_item(KIND_BYTE, frame[k]);
        if (truncate)
            push_item(KIND_TIMEOUT, 8'($urandom));
    endtask

    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 6))
            0:       return TYPE_01;
            1:       return TYPE_02;
            2:       return TYPE_03;
            3:       return TYPE_04;
            4:       return TYPE_05;
            5:       return TYPE_SYNC;
            default: return TYPE_PAYLOAD82;
        endcase
    endfunction

    initial begin
        int roll;
        sb         = new();
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_kind     = KIND_BYTE;
        i_rx_byte  = 8'h00;
        items_sent = 0;
        quiet      = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // timeout with nothing open, then bytes that are not type codes
        push_item(KIND_TIMEOUT, 8'hFF);
        push_item(KIND_BYTE, 8'h00);
        push_item(KIND_BYTE, 8'hFF);
        push_item(KIND_BYTE, 8'h81);
        send_frame(TYPE_01, 0, 1'b1, 1'b0);
        send_frame(TYPE_SYNC, 0, 1'b1, 1'b0);
        send_frame(TYPE_PAYLOAD82, 2, 1'b0, 1'b0);
        send_frame(TYPE_05, 0, 1'b1, 1'b1);

        // longest packet reaches the top offset
        send_frame(TYPE_PAYLOAD82, 255, 1'b1, 1'b0);

        while (items_sent < ITEM_TARGET) begin
            roll = $urandom_range(0, 99);
            if (roll < 6)
                push_item(KIND_TIMEOUT, 8'($urandom));
            else if (roll < 14)
                push_item(KIND_BYTE, 8'($urandom));
            else
                send_frame(pick_type(),
                           ($urandom_range(0, 79) == 0) ? 255 : $urandom_range(0, 12),
                           $urandom_range(0, 3) != 0, $urandom_range(0, 9) == 0);
        end
        i_valid = 1'b0;

        while (sb.frames_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d input transfers, checked %0d output transfers (max offset %0d)",
                 items_sent, sb.results_checked, sb.max_offset);
        $display("Closed %0d packets, %0d with bad checksum; %0d aborted by timeout",
                 sb.frames_closed, sb.sum_errors_seen, sb.aborts_seen);
        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/pdf_pkg.sv
sv/pdf_in_stage.sv
sv/pdf_framer.sv
sv/pdf_out_stage.sv
sv/packet_deframer_with_checksum_unit.sv
sv/pdf_checker.sv
test/testbench.sv
